/* rtl/rva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_pkg
// types, widths and constants shared by the vector rotation pipeline
// ----------------------------------------------------------------------------
package rva_pkg;

    localparam int RVA_CORDIC_STAGES = 16;

    localparam int ZW = 34;   // angle accumulator, Q.30
    localparam int XW = 33;   // cordic x/y, Q.30
    localparam int CW = 18;   // cosine/sine, Q.16
    localparam int TW = 19;   // 1 - cos, Q.16
    localparam int MW = 24;   // matrix entry, Q.16

    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } t_out;

    typedef struct packed {
        logic signed [MW-1:0] m00;
        logic signed [MW-1:0] m01;
        logic signed [MW-1:0] m02;
        logic signed [MW-1:0] m10;
        logic signed [MW-1:0] m11;
        logic signed [MW-1:0] m12;
        logic signed [MW-1:0] m20;
        logic signed [MW-1:0] m21;
        logic signed [MW-1:0] m22;
    } t_mat;

    // atan(2^-i) in Q.30, rounded to nearest
    function automatic logic signed [ZW-1:0] step_atan(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            default: r = 34'sd1 <<< (30 - i);
        endcase
        return r;
    endfunction

endpackage

/* rtl/rva_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_cordic
// quadrant fold and pipelined rotation-mode cordic, one stage per register
// ----------------------------------------------------------------------------
module rva_cordic
    import rva_pkg::*;
#(
    parameter int CORDIC_STAGES = RVA_CORDIC_STAGES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_in                  i_item,
    output logic                 o_valid,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic                 o_flip,
    output t_in                  o_item
);

    logic signed [ZW-1:0] r_z    [0:CORDIC_STAGES];
    logic signed [XW-1:0] r_x    [0:CORDIC_STAGES];
    logic signed [XW-1:0] r_y    [0:CORDIC_STAGES];
    logic                 r_flip [0:CORDIC_STAGES];
    logic                 r_vld  [0:CORDIC_STAGES];
    t_in                  r_item [0:CORDIC_STAGES];

    logic signed [ZW-1:0] w_z0;
    logic signed [ZW-1:0] n_z;
    logic                 n_flip;

    assign w_z0 = ZW'(i_item.angle) <<< 17;

    always_comb begin
        n_z    = w_z0;
        n_flip = 1'b0;
        if (w_z0 > HALF_PI_Q30) begin
            n_z    = w_z0 - PI_Q30;
            n_flip = 1'b1;
        end else if (w_z0 < -HALF_PI_Q30) begin
            n_z    = w_z0 + PI_Q30;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_z[0]    <= n_z;
        r_x[0]    <= GAIN_Q30;
        r_y[0]    <= '0;
        r_flip[0] <= n_flip;
        r_item[0] <= i_item;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            if (!r_z[i][ZW-1]) begin
                r_x[i+1] <= r_x[i] - w_dx;
                r_y[i+1] <= r_y[i] + w_dy;
                r_z[i+1] <= r_z[i] - step_atan(i);
            end else begin
                r_x[i+1] <= r_x[i] + w_dx;
                r_y[i+1] <= r_y[i] - w_dy;
                r_z[i+1] <= r_z[i] + step_atan(i);
            end
            r_flip[i+1] <= r_flip[i];
            r_item[i+1] <= r_item[i];
        end
    end

    assign o_valid = r_vld[CORDIC_STAGES];
    assign o_x     = r_x[CORDIC_STAGES];
    assign o_y     = r_y[CORDIC_STAGES];
    assign o_flip  = r_flip[CORDIC_STAGES];
    assign o_item  = r_item[CORDIC_STAGES];

endmodule

/* rtl/rva_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_matrix
// rounds cos/sin and builds the rotation matrix in three register stages
// ----------------------------------------------------------------------------
module rva_matrix
    import rva_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic                 i_flip,
    input  t_in                  i_item,
    output logic                 o_valid,
    output t_mat                 o_mat,
    output t_in                  o_item
);

    // stage a
    logic                 r_va;
    logic signed [CW-1:0] r_c_a;
    logic signed [CW-1:0] r_s_a;
    logic signed [TW-1:0] r_t_a;
    logic signed [31:0]   r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    t_in                  r_item_a;
    // stage b
    logic                 r_vb;
    logic signed [50:0]   r_txx, r_tyy, r_tzz, r_txy, r_txz, r_tyz;
    logic signed [33:0]   r_sx, r_sy, r_sz;
    logic signed [CW-1:0] r_c_b;
    t_in                  r_item_b;
    // stage c
    logic                 r_vc;
    t_mat                 r_mat;
    t_in                  r_item_c;

    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_y;
    logic signed [XW-1:0] w_xr;
    logic signed [XW-1:0] w_yr;

    assign w_x  = i_flip ? -i_x : i_x;
    assign w_y  = i_flip ? -i_y : i_y;
    assign w_xr = (w_x + 33'sd8192) >>> 14;
    assign w_yr = (w_y + 33'sd8192) >>> 14;

    function automatic logic signed [MW-1:0] entry(
        input logic signed [50:0]   tp,
        input logic signed [33:0]   sp,
        input logic                 neg,
        input logic signed [CW-1:0] c,
        input logic                 diag
    );
        logic signed [51:0] acc;
        acc = 52'(tp) + 52'sd134217728;
        if (neg) acc = acc - (52'(sp) <<< 14);
        else     acc = acc + (52'(sp) <<< 14);
        if (diag) acc = acc + (52'(c) <<< 28);
        return acc[51:28];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
        r_c_a    <= w_xr[CW-1:0];
        r_s_a    <= w_yr[CW-1:0];
        r_t_a    <= TW'(65536) - TW'($signed(w_xr[CW-1:0]));
        r_xx     <= 32'(i_item.axis_x) * 32'(i_item.axis_x);
        r_yy     <= 32'(i_item.axis_y) * 32'(i_item.axis_y);
        r_zz     <= 32'(i_item.axis_z) * 32'(i_item.axis_z);
        r_xy     <= 32'(i_item.axis_x) * 32'(i_item.axis_y);
        r_xz     <= 32'(i_item.axis_x) * 32'(i_item.axis_z);
        r_yz     <= 32'(i_item.axis_y) * 32'(i_item.axis_z);
        r_item_a <= i_item;

        r_txx    <= 51'(r_t_a) * 51'(r_xx);
        r_tyy    <= 51'(r_t_a) * 51'(r_yy);
        r_tzz    <= 51'(r_t_a) * 51'(r_zz);
        r_txy    <= 51'(r_t_a) * 51'(r_xy);
        r_txz    <= 51'(r_t_a) * 51'(r_xz);
        r_tyz    <= 51'(r_t_a) * 51'(r_yz);
        r_sx     <= 34'(r_s_a) * 34'(r_item_a.axis_x);
        r_sy     <= 34'(r_s_a) * 34'(r_item_a.axis_y);
        r_sz     <= 34'(r_s_a) * 34'(r_item_a.axis_z);
        r_c_b    <= r_c_a;
        r_item_b <= r_item_a;

        r_mat.m00 <= entry(r_txx, '0,   1'b0, r_c_b, 1'b1);
        r_mat.m01 <= entry(r_txy, r_sz, 1'b1, r_c_b, 1'b0);
        r_mat.m02 <= entry(r_txz, r_sy, 1'b0, r_c_b, 1'b0);
        r_mat.m10 <= entry(r_txy, r_sz, 1'b0, r_c_b, 1'b0);
        r_mat.m11 <= entry(r_tyy, '0,   1'b0, r_c_b, 1'b1);
        r_mat.m12 <= entry(r_tyz, r_sx, 1'b1, r_c_b, 1'b0);
        r_mat.m20 <= entry(r_txz, r_sy, 1'b1, r_c_b, 1'b0);
        r_mat.m21 <= entry(r_tyz, r_sx, 1'b0, r_c_b, 1'b0);
        r_mat.m22 <= entry(r_tzz, '0,   1'b0, r_c_b, 1'b1);
        r_item_c  <= r_item_b;
    end

    assign o_valid = r_vc;
    assign o_mat   = r_mat;
    assign o_item  = r_item_c;

endmodule

/* rtl/rva_apply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_apply
// multiplies the vector by the matrix, rounds and saturates to Q2.14
// ----------------------------------------------------------------------------
module rva_apply
    import rva_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_mat i_mat,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    logic               r_vd;
    logic signed [39:0] r_p [0:8];
    logic               r_ve;
    t_out               r_res;

    function automatic logic signed [15:0] fin(
        input logic signed [39:0] a,
        input logic signed [39:0] b,
        input logic signed [39:0] c
    );
        logic signed [41:0] acc;
        logic signed [25:0] q;
        acc = 42'(a) + 42'(b) + 42'(c) + 42'sd32768;
        q   = acc[41:16];
        if (q > 26'sd32767)       return 16'sh7fff;
        else if (q < -26'sd32768) return 16'sh8000;
        else                      return q[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            r_vd <= i_valid;
            r_ve <= r_vd;
        end
        r_p[0] <= 40'(i_mat.m00) * 40'(i_item.vec_x);
        r_p[1] <= 40'(i_mat.m01) * 40'(i_item.vec_y);
        r_p[2] <= 40'(i_mat.m02) * 40'(i_item.vec_z);
        r_p[3] <= 40'(i_mat.m10) * 40'(i_item.vec_x);
        r_p[4] <= 40'(i_mat.m11) * 40'(i_item.vec_y);
        r_p[5] <= 40'(i_mat.m12) * 40'(i_item.vec_z);
        r_p[6] <= 40'(i_mat.m20) * 40'(i_item.vec_x);
        r_p[7] <= 40'(i_mat.m21) * 40'(i_item.vec_y);
        r_p[8] <= 40'(i_mat.m22) * 40'(i_item.vec_z);
        r_res.out_x <= fin(r_p[0], r_p[1], r_p[2]);
        r_res.out_y <= fin(r_p[3], r_p[4], r_p[5]);
        r_res.out_z <= fin(r_p[6], r_p[7], r_p[8]);
    end

    assign o_valid  = r_ve;
    assign o_result = r_res;

endmodule

/* rtl/rotate_vector_about_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_vector_about_axis
// rotates a vector about a unit axis by an angle (Rodrigues), fixed point
//
//   port      dir  transfer
//   start     in   item taken when start is high and busy is low
//   i_item    in   angle, axis and vector
//   busy      out  always low, the pipeline never holds off
//   o_valid   out  one-cycle strobe per result
//   o_result  out  rotated vector, saturated
//
// one item per cycle; each item passes through the fold register, the cordic
// stages, the matrix stages and the product stages in that order
// synchronous reset clears only the valid bits of the pipeline
// results cannot be stalled and leave exactly once
// ----------------------------------------------------------------------------
module rotate_vector_about_axis
    import rva_pkg::*;
#(
    parameter int CORDIC_STAGES = RVA_CORDIC_STAGES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_valid,
    output t_out o_result
);

    localparam int LAT = CORDIC_STAGES + 6;

    logic                 w_cv;
    logic signed [XW-1:0] w_cx;
    logic signed [XW-1:0] w_cy;
    logic                 w_cflip;
    t_in                  w_citem;
    logic                 w_mv;
    t_mat                 w_mat;
    t_in                  w_mitem;

    assign busy = 1'b0;

    rva_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (w_cv),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_flip  (w_cflip),
        .o_item  (w_citem)
    );

    rva_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cv),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_flip  (w_cflip),
        .i_item  (w_citem),
        .o_valid (w_mv),
        .o_mat   (w_mat),
        .o_item  (w_mitem)
    );

    rva_apply u_apply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mv),
        .i_mat    (w_mat),
        .i_item   (w_mitem),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_out_has_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching transfer");
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result right after reset");
    a_mid_has_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cv |-> $past(start, CORDIC_STAGES + 1))
        else $error("cordic output without transfer");
`endif

endmodule

/* test/rotate_vector_about_axis_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_vector_about_axis_tb
// drives angle, axis and vector transfers into the rotation pipeline and
// compares each rotated vector with a bit-exact fixed point predictor
// ----------------------------------------------------------------------------
module rotate_vector_about_axis_tb;
    import rva_pkg::*;

    localparam int LATENCY = RVA_CORDIC_STAGES + 6;
    localparam int N_DIRECTED = 14;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_item;
    logic busy;
    logic o_valid;
    t_out o_result;

    t_out rotated_mem [0:4095];
    int   rot_wr = 0;
    int   rot_rd = 0;
    int   n_fail;
    int   sender_idle;

    rotate_vector_about_axis u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint floor_sh(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_q30(input int i);
        case (i)
            0:  return 64'd843314857;
            1:  return 64'd497837829;
            2:  return 64'd263043837;
            3:  return 64'd133525159;
            4:  return 64'd67021687;
            5:  return 64'd33543516;
            6:  return 64'd16775851;
            7:  return 64'd8388437;
            8:  return 64'd4194283;
            9:  return 64'd2097149;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    function automatic longint entry(input longint t, ua, ub, sg, s, uc, c,
                                     input bit diag);
        longint acc;
        acc = t * ua * ub + sg * s * uc * 16384;
        if (diag) acc += c * 268435456;
        return floor_sh(acc + (longint'(1) << 27), 28);
    endfunction

    function automatic t_out rotate(input t_in it);
        longint z, x, y, dx, dy, c, s, t, acc, q;
        longint u[3], v[3], m[3][3];
        bit flip;
        t_out r;
        z = longint'(it.angle) * 131072;
        u[0] = it.axis_x; u[1] = it.axis_y; u[2] = it.axis_z;
        v[0] = it.vec_x;  v[1] = it.vec_y;  v[2] = it.vec_z;
        flip = 1'b0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426; flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426; flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < RVA_CORDIC_STAGES; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_q30(i);
            end else begin
                x += dx; y -= dy; z += atan_q30(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = floor_sh(x + 8192, 14);
        s = floor_sh(y + 8192, 14);
        t = 65536 - c;
        m[0][0] = entry(t, u[0], u[0], 0, s, 0, c, 1);
        m[0][1] = entry(t, u[0], u[1], -1, s, u[2], c, 0);
        m[0][2] = entry(t, u[0], u[2], 1, s, u[1], c, 0);
        m[1][0] = entry(t, u[0], u[1], 1, s, u[2], c, 0);
        m[1][1] = entry(t, u[1], u[1], 0, s, 0, c, 1);
        m[1][2] = entry(t, u[1], u[2], -1, s, u[0], c, 0);
        m[2][0] = entry(t, u[0], u[2], -1, s, u[1], c, 0);
        m[2][1] = entry(t, u[1], u[2], 1, s, u[0], c, 0);
        m[2][2] = entry(t, u[2], u[2], 0, s, 0, c, 1);
        for (int k = 0; k < 3; k++) begin
            acc = m[k][0] * v[0] + m[k][1] * v[1] + m[k][2] * v[2];
            q = floor_sh(acc + 32768, 16);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            if (k == 0) r.out_x = q[15:0];
            else if (k == 1) r.out_y = q[15:0];
            else r.out_z = q[15:0];
        end
        return r;
    endfunction

    task automatic send(input t_in it);
        while ($urandom_range(99) < sender_idle) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk iff !busy);
        rotated_mem[rot_wr[11:0]] = rotate(it);
        rot_wr++;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rnd_field();
        case ($urandom_range(5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h4000;
            3:       return 16'hc000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in rnd_item();
        t_in it;
        int a;
        it.angle = rnd_field();
        if ($urandom_range(3) != 0)
            it.angle = 16'($signed($urandom_range(51472)) - 25736);
        it.vec_x = rnd_field(); it.vec_y = rnd_field(); it.vec_z = rnd_field();
        a = $urandom_range(3);
        if (a == 0) begin
            it.axis_x = rnd_field(); it.axis_y = rnd_field(); it.axis_z = rnd_field();
        end else begin
            it.axis_x = '0; it.axis_y = '0; it.axis_z = '0;
            case ($urandom_range(2))
                0: it.axis_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                1: it.axis_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                default: begin
                    it.axis_x = 16'sd9459; it.axis_y = -16'sd9459;
                    it.axis_z = 16'sd9459;
                end
            endcase
        end
        return it;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid) begin
            if (rot_rd == rot_wr) begin
                $error("result with no transfer pending");
                n_fail++;
            end else begin
                exp_r = rotated_mem[rot_rd[11:0]];
                rot_rd++;
                if (o_result.out_x !== exp_r.out_x) begin
                    $error("out_x exp %0d got %0d", exp_r.out_x, o_result.out_x);
                    n_fail++;
                end
                if (o_result.out_y !== exp_r.out_y) begin
                    $error("out_y exp %0d got %0d", exp_r.out_y, o_result.out_y);
                    n_fail++;
                end
                if (o_result.out_z !== exp_r.out_z) begin
                    $error("out_z exp %0d got %0d", exp_r.out_z, o_result.out_z);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_in directed[N_DIRECTED];
        int cyc;
        // angle, axis x y z, vector x y z
        directed[0]  = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0};
        directed[1]  = '{16'sd12868, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0};
        directed[2]  = '{-16'sd12868, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0};
        directed[3]  = '{16'sd25736, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0};
        directed[4]  = '{-16'sd25736, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
        directed[5]  = '{16'sh7fff, 16'sd0, 16'sd0, 16'sd16384, 16'sh7fff, 16'sh8000, 16'sd0};
        directed[6]  = '{16'sh8000, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000};
        directed[7]  = '{16'sd6434, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                         16'sh7fff, 16'sh7fff, 16'sh7fff};
        directed[8]  = '{16'sd6434, 16'sh8000, 16'sh8000, 16'sh8000,
                         16'sh8000, 16'sh8000, 16'sh8000};
        directed[9]  = '{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000, 16'sd1};
        directed[10] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        directed[11] = '{16'sd4000, 16'sd9459, 16'sd9459, 16'sd9459,
                         16'sd16384, -16'sd16384, 16'sd8000};
        directed[12] = '{16'sd25737, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
        directed[13] = '{-16'sd25737, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd5, -16'sd5, 16'sd3};
        n_fail = 0;
        sender_idle = 20;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[k]) send(directed[k]);
        for (int n = 0; n < 1900; n++) begin
            if (n == 600) sender_idle = 81;
            if (n == 1200) sender_idle = 0;
            send(rnd_item());
        end
        start <= 1'b0;
        cyc = 0;
        while (rot_rd != rot_wr && cyc < 10 * LATENCY) begin
            @(negedge i_clk);
            cyc++;
        end
        repeat (LATENCY + 4) @(negedge i_clk);
        if (n_fail == 0 && rot_rd == rot_wr)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
